/* rtl/core/fjw_pkg.sv */
// Shared constants, types and the stage record of the flux jitter window detector.
`default_nettype none

package fjw_pkg;

  // Window geometry and field widths
  localparam int HALF_WINDOW   = 8;
  localparam int SAMPLE_BITS   = 16;
  localparam int POSITION_BITS = 24;
  localparam int THRESH_BITS   = 16;
  localparam int WINDOW_LEN    = 2 * HALF_WINDOW + 1;

  // Sum of the line, sum of squares, and the width of the variance compare
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int SQ_BITS  = 2 * SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int CMP_BITS = 2 * SUM_BITS + 1;

  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic [2*SAMPLE_BITS-1:0] square_t;
  typedef logic [POSITION_BITS-1:0] position_t;
  typedef logic [THRESH_BITS-1:0]   thresh_t;
  typedef logic [SUM_BITS-1:0]      sum_t;
  typedef logic [SQ_BITS-1:0]       sq_sum_t;
  typedef logic [CMP_BITS-1:0]      cmp_t;

  localparam thresh_t   THRESH_RESET = thresh_t'(100);
  localparam position_t POSITION_MAX = '1;
  localparam position_t FIRST_TESTED = position_t'(2 * HALF_WINDOW);
  localparam sum_t      SUM_LIMIT    = sum_t'(WINDOW_LEN * ((2 ** SAMPLE_BITS) - 1));

  // Window state of one transaction, handed from the window stage to the test stage
  typedef struct packed {
    logic      valid;
    logic      test;
    position_t pos;
    sum_t      sum;
    sq_sum_t   sq;
  } win_t;

endpackage

`default_nettype wire

/* rtl/core/fjw_if.sv */
// Channel interfaces: sample input, position output and threshold configuration.
`default_nettype none

interface fjw_in_if;
  logic               valid;
  logic               ready;
  fjw_pkg::sample_t   flux_sample;
  logic               restart;

  modport source (output valid, output flux_sample, output restart, input ready);
  modport sink   (input valid, input flux_sample, input restart, output ready);
endinterface

interface fjw_out_if;
  logic                valid;
  logic                ready;
  fjw_pkg::position_t  weak_position;

  modport source (output valid, output weak_position, input ready);
  modport sink   (input valid, input weak_position, output ready);
endinterface

interface fjw_cfg_if;
  logic              valid;
  logic              ready;
  fjw_pkg::thresh_t  jitter_threshold;

  modport source (output valid, output jitter_threshold, input ready);
  modport sink   (input valid, input jitter_threshold, output ready);
endinterface

`default_nettype wire

/* rtl/core/fjw_window.sv */
// Input register, sample delay line and running window sums.
`default_nettype none

module fjw_window (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  fjw_in_if.sink              sample_i,
  input  wire logic           win_ready_i,
  output fjw_pkg::win_t       win_o
);

  logic             s0_valid_q, s0_valid_d;
  fjw_pkg::sample_t s0_sample_q;
  logic             s0_restart_q;

  fjw_pkg::sample_t   line_q [fjw_pkg::WINDOW_LEN];
  fjw_pkg::sample_t   line_d [fjw_pkg::WINDOW_LEN];
  fjw_pkg::sum_t      sum_q, sum_d;
  fjw_pkg::sq_sum_t   sq_q, sq_d;
  fjw_pkg::position_t idx_q, idx_d;
  fjw_pkg::position_t pos_q, pos_d;
  logic               test_q, test_d;
  logic               v1_q, v1_d;

  logic               s1_free;
  logic               adv0;
  logic               take;
  fjw_pkg::sample_t   old_sample;
  fjw_pkg::square_t   new_square;
  fjw_pkg::square_t   old_square;
  fjw_pkg::sum_t      base_sum;
  fjw_pkg::sq_sum_t   base_sq;

  // Handshake: the input register frees up whenever the window stage can take its item
  assign s1_free        = !v1_q || win_ready_i;
  assign adv0           = s0_valid_q && s1_free;
  assign sample_i.ready = !s0_valid_q || s1_free;
  assign take           = sample_i.valid && sample_i.ready;

  assign s0_valid_d = take ? 1'b1 : (adv0 ? 1'b0 : s0_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (take) begin
      s0_sample_q  <= sample_i.flux_sample;
      s0_restart_q <= sample_i.restart;
    end
  end

  // Drop the oldest sample, add the new one; a restart starts from an empty window
  always_comb begin
    old_sample = s0_restart_q ? '0 : line_q[fjw_pkg::WINDOW_LEN-1];
    base_sum   = s0_restart_q ? '0 : sum_q;
    base_sq    = s0_restart_q ? '0 : sq_q;
    new_square = s0_sample_q * s0_sample_q;
    old_square = old_sample * old_sample;
    sum_d = base_sum - fjw_pkg::SUM_BITS'(old_sample) + fjw_pkg::SUM_BITS'(s0_sample_q);
    sq_d  = base_sq - fjw_pkg::SQ_BITS'(old_square) + fjw_pkg::SQ_BITS'(new_square);
  end

  // Shift the delay line
  always_comb begin
    line_d[0] = s0_sample_q;
    for (int k = 1; k < fjw_pkg::WINDOW_LEN; k++) begin
      line_d[k] = s0_restart_q ? '0 : line_q[k-1];
    end
  end

  // Position of this sample and the saturating index of the next one
  always_comb begin
    pos_d  = s0_restart_q ? '0 : idx_q;
    idx_d  = (pos_d == fjw_pkg::POSITION_MAX) ? pos_d : pos_d + 1'b1;
    test_d = (pos_d >= fjw_pkg::FIRST_TESTED);
  end

  assign v1_d = adv0 ? 1'b1 : (win_ready_i ? 1'b0 : v1_q);

  // Advance the window state once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      sum_q  <= '0;
      sq_q   <= '0;
      idx_q  <= '0;
      pos_q  <= '0;
      test_q <= 1'b0;
      for (int k = 0; k < fjw_pkg::WINDOW_LEN; k++) begin
        line_q[k] <= '0;
      end
    end else begin
      v1_q <= v1_d;
      if (adv0) begin
        sum_q  <= sum_d;
        sq_q   <= sq_d;
        idx_q  <= idx_d;
        pos_q  <= pos_d;
        test_q <= test_d;
        for (int k = 0; k < fjw_pkg::WINDOW_LEN; k++) begin
          line_q[k] <= line_d[k];
        end
      end
    end
  end

  assign win_o.valid = v1_q;
  assign win_o.test  = test_q;
  assign win_o.pos   = pos_q;
  assign win_o.sum   = sum_q;
  assign win_o.sq    = sq_q;

  // The running sum never exceeds a full window of maximum samples
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (sum_q <= fjw_pkg::SUM_LIMIT))
    else $error("window sum out of range");

  // A restart leaves only its own sample in the window
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv0 && s0_restart_q) |=>
      (pos_q == '0 && sum_q == fjw_pkg::SUM_BITS'($past(s0_sample_q))))
    else $error("restart did not clear the window");

  // The next index follows the held position unless saturated
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (idx_q == pos_q + 1'b1 || pos_q == fjw_pkg::POSITION_MAX))
    else $error("sample index out of step");

  // Only a full window is tested
  a_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && test_q) |-> (pos_q >= fjw_pkg::FIRST_TESTED))
    else $error("partial window tested");

endmodule

`default_nettype wire

/* rtl/core/fjw_test.sv */
// Threshold register, variance compare and result register.
`default_nettype none

module fjw_test (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fjw_pkg::win_t win_i,
  output logic               win_ready_o,
  fjw_cfg_if.sink            cfg_i,
  fjw_out_if.source          result_o
);

  fjw_pkg::thresh_t   thr_q;
  fjw_pkg::square_t   thr_sq_q;
  fjw_pkg::cmp_t      limit_q, limit_d;
  fjw_pkg::cmp_t      sum_sq;
  fjw_pkg::cmp_t      lhs;
  fjw_pkg::cmp_t      rhs;
  logic               hit;
  logic               out_free;
  logic               vo_q, vo_d;
  fjw_pkg::position_t wpos_q;

  // Configuration is always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= fjw_pkg::THRESH_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.jitter_threshold;
    end
  end

  // Scale the squared threshold by the squared window length
  assign limit_d = fjw_pkg::CMP_BITS'(thr_sq_q) *
                   fjw_pkg::CMP_BITS'(fjw_pkg::WINDOW_LEN * fjw_pkg::WINDOW_LEN);

  always_ff @(posedge clk_i) begin
    thr_sq_q <= thr_q * thr_q;
    limit_q  <= limit_d;
  end

  // N*sumsq > sum^2 + N^2*threshold^2
  always_comb begin
    sum_sq = fjw_pkg::CMP_BITS'(win_i.sum) * fjw_pkg::CMP_BITS'(win_i.sum);
    lhs    = fjw_pkg::CMP_BITS'(win_i.sq) * fjw_pkg::CMP_BITS'(fjw_pkg::WINDOW_LEN);
    rhs    = sum_sq + limit_q;
    hit    = lhs > rhs;
  end

  // Result register; the window stage advances whenever this register can load
  assign out_free    = !vo_q || result_o.ready;
  assign win_ready_o = out_free;
  assign vo_d        = out_free ? (win_i.valid && win_i.test && hit) : vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      wpos_q <= win_i.pos - fjw_pkg::POSITION_BITS'(fjw_pkg::HALF_WINDOW);
    end
  end

  assign result_o.valid         = vo_q;
  assign result_o.weak_position = wpos_q;

endmodule

`default_nettype wire

/* rtl/core/flux_jitter_window_detector_core.sv */
// Flux jitter window detector: top level joining the window and test stages.
//
// Usage:
//   sample_i carries one flux interval sample per transaction, with a restart
//   flag on the first sample of a track. From the 17th sample of a track on,
//   every sample completes a window whose centre sample (8 back) is tested:
//   when 17*sumsq - sum^2 > 289*threshold^2, that centre's track position is
//   sent on result_o. Other transactions produce no result.
//   cfg_i writes the threshold (reset value 100); write it only while idle.
// Path: a sample passes the input register, the window stage and the result register.
// Throughput: one sample per cycle while no result waits on result_o, set by
//   the running-sum update of the window register stage; the test stage's
//   multiplier and compare is the longest path.
// Reset: clears the window, sums, track position and all valid flags.
// Stall: while a result waits on result_o, the input register and
//   window stage still fill before sample_i.ready drops.
`default_nettype none

module flux_jitter_window_detector_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fjw_in_if.sink      sample_i,
  fjw_cfg_if.sink     cfg_i,
  fjw_out_if.source   result_o
);

  fjw_pkg::win_t win;
  logic          win_ready;

  // Delay line and running sums
  fjw_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .win_ready_i (win_ready),
    .win_o       (win)
  );

  // Variance test and result register
  fjw_test u_test (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_i       (win),
    .win_ready_o (win_ready),
    .cfg_i       (cfg_i),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

/* tb/sv/flux_jitter_window_detector_core_tb.sv */
// Testbench for the flux jitter window detector: directed and random tracks, checked per result.
`timescale 1ns / 1ps

module flux_jitter_window_detector_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned SETTLE_TICKS = 4;
  localparam int unsigned IDLE_PCT     = 6;

  logic clk_i;
  logic rst_ni;

  fjw_in_if  sample_ch ();
  fjw_cfg_if cfg_ch ();
  fjw_out_if result_ch ();

  flux_jitter_window_detector_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .cfg_i    (cfg_ch),
    .result_o (result_ch)
  );

  // Predictor state: the window line, its write slot, track index and threshold
  fjw_pkg::sample_t     track_window [fjw_pkg::WINDOW_LEN];
  int unsigned          track_slot;
  fjw_pkg::position_t   track_index;
  fjw_pkg::thresh_t     threshold_model;

  // Positions the block must still report, oldest first
  fjw_pkg::position_t   weak_pos_q [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          idle_enable;
  int unsigned hold_cycles;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d positions outstanding",
               cycle_count, weak_pos_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input fjw_pkg::position_t want,
                                 input fjw_pkg::position_t got);
    $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycle_count);
    mismatch_count++;
  endtask

  // Clear the predicted track: window, slot and index
  function automatic void clear_track_model();
    for (int k = 0; k < fjw_pkg::WINDOW_LEN; k++) track_window[k] = '0;
    track_slot  = 0;
    track_index = '0;
  endfunction

  // Advance the window by one sample; return 1 with the flagged centre position
  function automatic bit predict_weak_position(input fjw_pkg::sample_t smp, input bit restart,
                                               output fjw_pkg::position_t pos);
    logic [63:0]        sum_acc;
    logic [63:0]        sq_acc;
    logic [63:0]        lhs;
    logic [63:0]        rhs;
    fjw_pkg::position_t centre_src;
    sum_acc = '0;
    sq_acc  = '0;
    pos     = '0;
    if (restart) clear_track_model();
    track_window[track_slot] = smp;
    track_slot = (track_slot + 1 >= fjw_pkg::WINDOW_LEN) ? 0 : track_slot + 1;
    for (int k = 0; k < fjw_pkg::WINDOW_LEN; k++) begin
      sum_acc += 64'(track_window[k]);
      sq_acc  += 64'(track_window[k]) * 64'(track_window[k]);
    end
    centre_src = track_index;
    if (track_index != fjw_pkg::POSITION_MAX) track_index = track_index + 1'b1;
    if (centre_src < fjw_pkg::FIRST_TESTED) return 1'b0;
    lhs = 64'(fjw_pkg::WINDOW_LEN) * sq_acc;
    rhs = sum_acc * sum_acc
        + 64'(fjw_pkg::WINDOW_LEN * fjw_pkg::WINDOW_LEN)
          * 64'(threshold_model) * 64'(threshold_model);
    if (lhs <= rhs) return 1'b0;
    pos = fjw_pkg::position_t'(centre_src - fjw_pkg::position_t'(fjw_pkg::HALF_WINDOW));
    return 1'b1;
  endfunction

  // Drive result ready: random stalls, optional long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        result_ch.ready = 1'b0;
        hold_cycles--;
      end else if (idle_enable && $urandom_range(99) < IDLE_PCT) begin
        result_ch.ready = 1'b0;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  // Check each result transaction against the oldest predicted position
  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (weak_pos_q.size() == 0) begin
        report_mismatch("unexpected weak_position", '0, result_ch.weak_position);
      end else begin
        fjw_pkg::position_t want;
        want = weak_pos_q.pop_front();
        if (result_ch.weak_position !== want)
          report_mismatch("weak_position", want, result_ch.weak_position);
      end
    end
  end

  // Offer one sample and hold it until the block takes it
  task automatic send_sample(input fjw_pkg::sample_t smp, input bit restart);
    fjw_pkg::position_t pos;
    @(negedge clk_i);
    if (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      sample_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    sample_ch.valid       = 1'b1;
    sample_ch.flux_sample = smp;
    sample_ch.restart     = restart;
    do @(posedge clk_i); while (!sample_ch.ready);
    if (predict_weak_position(smp, restart, pos)) weak_pos_q.push_back(pos);
  endtask

  // Drop valid, drain all results, then let the pipeline empty
  task automatic settle_block();
    @(negedge clk_i);
    sample_ch.valid = 1'b0;
    while (weak_pos_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_threshold(input fjw_pkg::thresh_t value);
    settle_block();
    @(negedge clk_i);
    cfg_ch.valid            = 1'b1;
    cfg_ch.jitter_threshold = value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    threshold_model = value;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // One sample near base with uniform jitter of +/- amp, clamped to the field
  function automatic fjw_pkg::sample_t jitter_sample(input int unsigned base,
                                                     input int unsigned amp);
    int v;
    if (amp >= 65535) return fjw_pkg::sample_t'($urandom);
    v = int'(base) + int'($urandom_range(2 * amp)) - int'(amp);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return fjw_pkg::sample_t'(v);
  endfunction

  // Random tracks: mostly full windows, some short tracks and continued tracks
  task automatic send_tracks(input int unsigned total);
    int unsigned sent;
    int unsigned len;
    int unsigned amp;
    int unsigned base;
    int unsigned pick;
    bit          open_track;
    sent = 0;
    while (sent < total) begin
      pick = $urandom_range(99);
      if (pick < 10)      len = $urandom_range(1, 16);
      else if (pick < 90) len = $urandom_range(17, 120);
      else                len = $urandom_range(121, 300);
      case ($urandom_range(9))
        0:          amp = 0;
        1, 2, 3:    amp = $urandom_range(1, 200);
        4, 5, 6, 7: amp = $urandom_range(200, 3000);
        8:          amp = 65535;
        default:    amp = $urandom_range(3000, 30000);
      endcase
      base       = $urandom_range(65535);
      open_track = ($urandom_range(9) != 0);
      for (int unsigned k = 0; k < len && sent < total; k++) begin
        send_sample(jitter_sample(base, amp), open_track && k == 0);
        sent++;
      end
    end
  endtask

  // Extreme samples at the reset threshold, then a track too short to test
  task automatic test_default_threshold();
    for (int k = 0; k < 18; k++)
      send_sample(k[0] ? fjw_pkg::sample_t'(65535) : fjw_pkg::sample_t'(0), k == 0);
    for (int k = 0; k < 5; k++)
      send_sample(fjw_pkg::sample_t'($urandom), k == 0);
    settle_block();
  endtask

  // Zero threshold flags any uneven window; full-scale threshold flags none; then threshold one
  task automatic test_threshold_extremes();
    write_threshold('0);
    send_tracks(150);
    write_threshold('1);
    send_tracks(150);
    write_threshold(fjw_pkg::thresh_t'(1));
    send_tracks(150);
  endtask

  task automatic test_random_thresholds();
    for (int k = 0; k < 4; k++) begin
      write_threshold(fjw_pkg::thresh_t'($urandom_range(0, 3000)));
      send_tracks(150);
    end
    write_threshold(fjw_pkg::THRESH_RESET);
    send_tracks(100);
  endtask

  // Hold off results long enough that the block stalls its input
  task automatic test_output_stall();
    write_threshold('0);
    @(posedge clk_i);
    hold_cycles = 300;
    send_tracks(60);
    settle_block();
  endtask

  // Back-to-back transactions on both sides
  task automatic test_no_idle_stretch();
    write_threshold(fjw_pkg::thresh_t'($urandom_range(50, 1500)));
    idle_enable = 1'b0;
    send_tracks(350);
    settle_block();
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_ni                  = 1'b0;
    sample_ch.valid         = 1'b0;
    sample_ch.flux_sample   = '0;
    sample_ch.restart       = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.jitter_threshold = '0;
    result_ch.ready         = 1'b0;
    mismatch_count          = 0;
    cycle_count             = 0;
    idle_enable             = 1'b1;
    hold_cycles             = 0;
    threshold_model         = fjw_pkg::THRESH_RESET;
    clear_track_model();

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_threshold();
    test_threshold_extremes();
    test_random_thresholds();
    test_output_stall();
    test_no_idle_stretch();
    settle_block();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/fjw_pkg.sv
rtl/core/fjw_if.sv
rtl/core/fjw_window.sv
rtl/core/fjw_test.sv
rtl/core/flux_jitter_window_detector_core.sv
tb/sv/flux_jitter_window_detector_core_tb.sv
